// ===== rtl/dual_channel_reload_timer_assert.svh =====
// Assertion macros shared by the timer checker.
`ifndef DUAL_CHANNEL_RELOAD_TIMER_ASSERT_SVH
`define DUAL_CHANNEL_RELOAD_TIMER_ASSERT_SVH

// Clocked check that is switched off while reset is asserted.
`define DCRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define DCRT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dcrt_pkg.sv =====
// Package with command codes, register selects and control bit positions of the timer.
`timescale 1ns / 1ps
`default_nettype none

package dcrt_pkg;

  // Command codes.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Register selects.
  localparam logic [1:0] SEL_CTL   = 2'd0;
  localparam logic [1:0] SEL_LOAD  = 2'd1;
  localparam logic [1:0] SEL_COUNT = 2'd2;

  // Control/status layout.
  localparam int CTL_W = 12;
  localparam int BIT_UDT   = 1;
  localparam int BIT_ARHT  = 4;
  localparam int BIT_LOAD  = 5;
  localparam int BIT_ENIT  = 6;
  localparam int BIT_ENT   = 7;
  localparam int BIT_TINT  = 8;
  localparam int BIT_ENALL = 10;

  typedef logic [CTL_W-1:0] ctl_t;

  // Per-channel update requests from the decoder.
  typedef struct packed {
    logic tick;
    logic ctl_wr;
    logic load_wr;
    logic count_wr;
    logic peer_all_set;
    logic peer_all_clr;
  } dcrt_chan_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/dcrt_channel.sv =====
// One timer channel: control, load and count registers with tick and write logic.
`timescale 1ns / 1ps
`default_nettype none

module dcrt_channel
  import dcrt_pkg::*;
#(
  parameter int COUNTER_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire dcrt_chan_cmd_t           cmd,
  input  wire logic [31:0]              wdata,
  output ctl_t                          ctl_r,
  output ctl_t                          ctl_nxt,
  output logic [COUNTER_WIDTH-1:0]      load_r,
  output logic [COUNTER_WIDTH-1:0]      count_r
);

  logic [COUNTER_WIDTH-1:0] load_nxt;
  logic [COUNTER_WIDTH-1:0] count_nxt;
  logic [COUNTER_WIDTH-1:0] wdata_cw;
  logic [COUNTER_WIDTH-1:0] term;
  ctl_t                     wr_ctl;

  // Fit the 32-bit bus word to the counter width.
  if (COUNTER_WIDTH > 32) begin : g_wide
    assign wdata_cw = {{(COUNTER_WIDTH-32){1'b0}}, wdata};
  end else if (COUNTER_WIDTH == 32) begin : g_equal
    assign wdata_cw = wdata;
  end else begin : g_narrow
    assign wdata_cw = wdata[COUNTER_WIDTH-1:0];
  end

  // Terminal value is zero when counting down and all ones when counting up.
  assign term = ctl_r[BIT_UDT] ? '0 : '1;

  // Value a control write leaves: the flag clears only where a one is written; ENALL also sets ENT.
  always_comb begin
    wr_ctl = wdata[CTL_W-1:0];
    wr_ctl[BIT_TINT] = ctl_r[BIT_TINT] & ~wdata[BIT_TINT];
    if (wdata[BIT_ENALL]) begin
      wr_ctl[BIT_ENT] = 1'b1;
    end
  end

  // Next-state logic for the tick and the register writes.
  always_comb begin
    ctl_nxt   = ctl_r;
    load_nxt  = load_r;
    count_nxt = count_r;
    if (cmd.tick) begin
      if (ctl_r[BIT_LOAD]) begin
        count_nxt = load_r;
      end else if (ctl_r[BIT_ENT]) begin
        if (count_r == term) begin
          ctl_nxt[BIT_TINT] = 1'b1;
          if (ctl_r[BIT_ARHT]) begin
            count_nxt = load_r;
          end else begin
            ctl_nxt[BIT_ENT] = 1'b0;
          end
        end else if (ctl_r[BIT_UDT]) begin
          count_nxt = count_r - COUNTER_WIDTH'(1);
        end else begin
          count_nxt = count_r + COUNTER_WIDTH'(1);
        end
      end
    end
    if (cmd.ctl_wr) begin
      ctl_nxt = wr_ctl;
    end
    if (cmd.peer_all_set) begin
      ctl_nxt[BIT_ENALL] = 1'b1;
      ctl_nxt[BIT_ENT]   = 1'b1;
    end
    if (cmd.peer_all_clr) begin
      ctl_nxt[BIT_ENALL] = 1'b0;
    end
    if (cmd.load_wr) begin
      load_nxt = wdata_cw;
    end
    if (cmd.count_wr) begin
      count_nxt = wdata_cw;
    end
  end

  // Channel state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r   <= '0;
      load_r  <= '0;
      count_r <= '0;
    end else begin
      ctl_r   <= ctl_nxt;
      load_r  <= load_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dual_channel_reload_timer.sv =====
// A single update pass takes each access through the input, then the result register.
// Throughput: one tick or register access per cycle unless a stalled result is held.
// Each access sees the state left by the one before it, with no bubble between them.
// Reset (synchronous, active low) clears all control, load and count registers at once
// and empties both pipeline registers.
`timescale 1ns / 1ps
`default_nettype none

module dual_channel_reload_timer
  import dcrt_pkg::*;
#(
  parameter int COUNTER_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic        in_channel,
  input  wire logic [1:0]  in_reg_select,
  input  wire logic [31:0] in_write_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_read_data,
  output logic             out_irq
);

  logic        in_valid_r;
  logic [1:0]  cmd_r;
  logic        chan_r;
  logic [1:0]  sel_r;
  logic [31:0] wdata_r;
  logic        out_valid_r;
  logic [31:0] rdata_r;
  logic        irq_r;
  logic        advance;
  logic        take_in;
  logic [31:0] rdata_nxt;
  logic        irq_nxt;

  dcrt_chan_cmd_t           chan_cmd [2];
  ctl_t                     ctl_q    [2];
  ctl_t                     ctl_n    [2];
  logic [COUNTER_WIDTH-1:0] load_q   [2];
  logic [COUNTER_WIDTH-1:0] count_q  [2];
  logic [31:0]              load_rd  [2];
  logic [31:0]              count_rd [2];

  // Handshake: the held item moves on whenever the result register is free.
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && out_valid_r && out_stall;
  assign take_in   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_read_data = rdata_r;
  assign out_irq   = irq_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (take_in) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      cmd_r   <= in_command;
      chan_r  <= in_channel;
      sel_r   <= in_reg_select;
      wdata_r <= in_write_data;
    end
  end

  // Decode the held item into per-channel update requests.
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      chan_cmd[c] = '0;
    end
    if (advance) begin
      unique case (cmd_r)
        CMD_TICK: begin
          chan_cmd[0].tick = 1'b1;
          chan_cmd[1].tick = 1'b1;
        end
        CMD_WRITE: begin
          unique case (sel_r)
            SEL_CTL: begin
              chan_cmd[chan_r].ctl_wr        = 1'b1;
              chan_cmd[!chan_r].peer_all_set = wdata_r[BIT_ENALL];
              chan_cmd[!chan_r].peer_all_clr = !wdata_r[BIT_ENALL];
            end
            SEL_LOAD:  chan_cmd[chan_r].load_wr  = 1'b1;
            SEL_COUNT: chan_cmd[chan_r].count_wr = 1'b1;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // The two channels.
  for (genvar c = 0; c < 2; c++) begin : g_chan
    dcrt_channel #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_channel (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (chan_cmd[c]),
      .wdata   (wdata_r),
      .ctl_r   (ctl_q[c]),
      .ctl_nxt (ctl_n[c]),
      .load_r  (load_q[c]),
      .count_r (count_q[c])
    );

    // Only the low 32 bits of a counter are visible on the bus.
    if (COUNTER_WIDTH >= 32) begin : g_rd_wide
      assign load_rd[c]  = load_q[c][31:0];
      assign count_rd[c] = count_q[c][31:0];
    end else begin : g_rd_narrow
      assign load_rd[c]  = {{(32-COUNTER_WIDTH){1'b0}}, load_q[c]};
      assign count_rd[c] = {{(32-COUNTER_WIDTH){1'b0}}, count_q[c]};
    end
  end

  // Read mux and interrupt line after this step.
  always_comb begin
    rdata_nxt = '0;
    if (cmd_r == CMD_READ) begin
      unique case (sel_r)
        SEL_CTL:   rdata_nxt = {{(32-CTL_W){1'b0}}, ctl_q[chan_r]};
        SEL_LOAD:  rdata_nxt = load_rd[chan_r];
        SEL_COUNT: rdata_nxt = count_rd[chan_r];
        default:   rdata_nxt = '0;
      endcase
    end
    irq_nxt = (ctl_n[0][BIT_TINT] && ctl_n[0][BIT_ENIT]) ||
              (ctl_n[1][BIT_TINT] && ctl_n[1][BIT_ENIT]);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rdata_r <= rdata_nxt;
      irq_r   <= irq_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dcrt_checker.sv =====
// Port-level checker for the timer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "dual_channel_reload_timer_assert.svh"

module dcrt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_read_data,
  input wire logic        out_irq
);

  // Reset empties the result register.
  `DCRT_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid right after reset")

  // The input side only stalls while a finished result is held back.
  `DCRT_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stall without output stall")

  // A transfer in raises out_valid, through the input and result registers, when the output is not stalled.
  `DCRT_ASSERT(a_latency, (in_valid && !in_stall) ##1 !out_stall |=> out_valid, "result missing after transfer")

  // A stalled result stays put.
  `DCRT_ASSERT(a_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_read_data) && $stable(out_irq)), "stalled result changed")

endmodule

bind dual_channel_reload_timer dcrt_checker u_dcrt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_read_data (out_read_data),
  .out_irq       (out_irq)
);

`default_nettype wire
